[src/idr_pkg.sv]
`default_nettype none

package idr_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned HELD_W  = 11;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_READ_POS   = 3'd6,
    REQ_WRITE_POS  = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Response bookkeeping that travels alongside a memory access
  typedef struct packed {
    logic [HELD_W-1:0] items_held;
    status_e           status;
    logic              rd;        // response data comes from the ring read
  } meta_t;

endpackage

`default_nettype wire

[src/idr_ram.sv]
`default_nettype none

module idr_ram #(
  parameter int unsigned RING_DEPTH = 1024,
  parameter int unsigned ITEM_WIDTH = 32,
  localparam int unsigned AW = $clog2(RING_DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         addr_i,
  input  wire logic [ITEM_WIDTH-1:0] wdata_i,
  output logic      [ITEM_WIDTH-1:0] rdata_o
);

  logic [ITEM_WIDTH-1:0] mem [RING_DEPTH];
  logic [ITEM_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/idr_ctrl.sv]
`default_nettype none

module idr_ctrl #(
  parameter int unsigned RING_DEPTH = 1024,
  parameter int unsigned ITEM_WIDTH = 32,
  localparam int unsigned AW = $clog2(RING_DEPTH),
  localparam int unsigned CW = $clog2(RING_DEPTH + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_valid_i,
  input  wire idr_pkg::req_e                req_type_i,
  input  wire logic [idr_pkg::VALUE_W-1:0]  item_value_i,
  input  wire logic [idr_pkg::POS_W-1:0]    position_i,
  output logic                              mem_we_o,
  output logic                              mem_re_o,
  output logic      [AW-1:0]                mem_addr_o,
  output logic      [ITEM_WIDTH-1:0]        mem_wdata_o,
  output idr_pkg::meta_t                    meta_o
);

  localparam int unsigned CmpW = (CW > idr_pkg::POS_W) ? CW : idr_pkg::POS_W;
  localparam logic [AW:0] DepthW = (AW + 1)'(RING_DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(RING_DEPTH - 1);

  logic [AW-1:0]    front_q, front_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             full, empty, pos_ok;
  logic [AW-1:0]    front_dec, front_inc, off, slot;
  logic [AW:0]      sum;
  logic             we, re, at_front;
  idr_pkg::status_e status;

  assign full      = (cnt_q == CW'(RING_DEPTH));
  assign empty     = (cnt_q == '0);
  assign pos_ok    = (CmpW'(position_i) < CmpW'(cnt_q));
  assign front_dec = (front_q == '0) ? LastSlot : front_q - AW'(1);
  assign front_inc = (front_q == LastSlot) ? '0 : front_q + AW'(1);

  // offset from the front, wrapped once (offset is below the depth for every request that touches memory)
  assign sum  = {1'b0, front_q} + {1'b0, off};
  assign slot = (sum >= DepthW) ? AW'(sum - DepthW) : sum[AW-1:0];

  always_comb begin
    cnt_d    = cnt_q;
    front_d  = front_q;
    status   = idr_pkg::ST_OK;
    off      = '0;
    we       = 1'b0;
    re       = 1'b0;
    at_front = 1'b0;
    unique case (req_type_i)
      idr_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          status = idr_pkg::ST_FULL;
        end else begin
          we       = 1'b1;
          at_front = 1'b1;
          front_d  = front_dec;
          cnt_d    = cnt_q + CW'(1);
        end
      end
      idr_pkg::REQ_PUSH_BACK: begin
        off = AW'(cnt_q);
        if (full) begin
          status = idr_pkg::ST_FULL;
        end else begin
          we    = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end
      end
      idr_pkg::REQ_POP_FRONT, idr_pkg::REQ_PEEK_FRONT: begin
        if (empty) begin
          status = idr_pkg::ST_EMPTY;
        end else begin
          re = 1'b1;
          if (req_type_i == idr_pkg::REQ_POP_FRONT) begin
            front_d = front_inc;
            cnt_d   = cnt_q - CW'(1);
          end
        end
      end
      idr_pkg::REQ_POP_BACK, idr_pkg::REQ_PEEK_BACK: begin
        off = AW'(cnt_q - CW'(1));
        if (empty) begin
          status = idr_pkg::ST_EMPTY;
        end else begin
          re = 1'b1;
          if (req_type_i == idr_pkg::REQ_POP_BACK) begin
            cnt_d = cnt_q - CW'(1);
          end
        end
      end
      idr_pkg::REQ_READ_POS: begin
        off = AW'(position_i);
        if (!pos_ok) begin
          status = idr_pkg::ST_RANGE;
        end else begin
          re = 1'b1;
        end
      end
      idr_pkg::REQ_WRITE_POS: begin
        off = AW'(position_i);
        if (!pos_ok) begin
          status = idr_pkg::ST_RANGE;
        end else begin
          we = 1'b1;
        end
      end
      default: begin
        status = idr_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      cnt_q   <= '0;
    end else if (req_valid_i) begin
      front_q <= front_d;
      cnt_q   <= cnt_d;
    end
  end

  assign mem_we_o    = req_valid_i && we;
  assign mem_re_o    = req_valid_i && re;
  assign mem_addr_o  = at_front ? front_dec : slot;
  assign mem_wdata_o = ITEM_WIDTH'(item_value_i);

  assign meta_o.items_held = idr_pkg::HELD_W'(cnt_d);
  assign meta_o.status     = status;
  assign meta_o.rd         = re;

endmodule

`default_nettype wire

[src/indexed_deque_ring_unit.sv]
`default_nettype none

// Indexed deque on a single ring memory. Each input word is one request
// (push/pop/peek at either end, or read/overwrite at a position counted from
// the front) and yields exactly one output word carrying the data read, the
// item count after the request and a status code (ok, empty, full, position
// out of range). Failed requests leave the queue untouched and return zero
// data. Throughput is one request per clock while the output is not stalled. The
// front pointer and count live in flops and are updated at accept, while the
// ring entry is read or written in the same cycle through the memory's single port. A response
// moves from the memory read register and stage 1 into the output register. No
// clearing pass after reset: entries are only read after a push or write has
// filled them.
module indexed_deque_ring_unit #(
  parameter int unsigned RING_DEPTH = 1024,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [31:0] item_value, [41:32] position
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] req_type
  // response stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,   // [31:0] data_out, [42:32] items_held
  output logic      [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned AW = $clog2(RING_DEPTH);

  logic                  accept;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [ITEM_WIDTH-1:0] mem_wdata, mem_rdata;
  idr_pkg::meta_t        meta;

  // stage 1: waits on the memory read
  logic                  s1_valid_q, s1_valid_d;
  idr_pkg::meta_t        s1_meta_q;
  logic                  adv1;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [idr_pkg::VALUE_W-1:0]     out_data_q;
  idr_pkg::meta_t                  out_meta_q;

  // s1 moves on when the output register is free or draining this cycle
  assign adv1          = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  idr_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (accept),
    .req_type_i   (idr_pkg::req_e'(s_axis_tuser)),
    .item_value_i (s_axis_tdata[31:0]),
    .position_i   (s_axis_tdata[41:32]),
    .mem_we_o     (mem_we),
    .mem_re_o     (mem_re),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .meta_o       (meta)
  );

  // Reads are only issued at accept, so the read register holds while s1 stalls.
  idr_ram #(
    .RING_DEPTH (RING_DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv1) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv1) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
    end
    if (adv1) begin
      out_meta_q <= s1_meta_q;
      out_data_q <= s1_meta_q.rd ? idr_pkg::VALUE_W'(mem_rdata) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_meta_q.items_held, out_data_q};
  assign m_axis_tuser  = out_meta_q.status;

endmodule

`default_nettype wire

[src/idr_checker.sv]
`default_nettype none

module idr_checker #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [47:0] s_axis_tdata,
  input wire logic [2:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  localparam bit HeldVisible = (RING_DEPTH < 2048);
  localparam logic [10:0] DepthHeld = 11'(RING_DEPTH);

  // a stalled response word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("response changed while stalled");

  // failed requests return zero data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != idr_pkg::ST_OK) |-> m_axis_tdata[31:0] == '0)
    else $error("nonzero data on error response");

  // empty status only with zero items, full status only at capacity
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == idr_pkg::ST_EMPTY) |-> m_axis_tdata[42:32] == '0)
    else $error("empty status with items held");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HeldVisible && m_axis_tvalid && (m_axis_tuser == idr_pkg::ST_FULL)
      |-> m_axis_tdata[42:32] == DepthHeld)
    else $error("full status below capacity");

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HeldVisible && m_axis_tvalid |-> m_axis_tdata[42:32] <= DepthHeld)
    else $error("item count above capacity");

endmodule

bind indexed_deque_ring_unit idr_checker #(.RING_DEPTH(RING_DEPTH)) u_idr_checker (.*);

`default_nettype wire

[tb/indexed_deque_ring_unit_tb.sv]
`timescale 1ns / 100ps

module indexed_deque_ring_unit_tb;
  import idr_pkg::*;

  localparam int unsigned RING_DEPTH  = 1024;
  localparam int unsigned ITEM_WIDTH  = 32;
  localparam int unsigned IDLE_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int unsigned TAIL_CYCLES = 8;     // idle cycles after the last response
  localparam int unsigned MAX_PRINTS  = 30;

  typedef struct {
    logic [VALUE_W-1:0] data;
    logic [HELD_W-1:0]  held;
    status_e            status;
  } deque_reply_t;

  // Mirror of the deque: tracks ring contents, front index and count,
  // and keeps the replies that accepted requests are owed, oldest first.
  class deque_mirror;
    logic [VALUE_W-1:0] ring_mem [RING_DEPTH];
    logic [POS_W-1:0]   front_idx;
    int unsigned        fill_count;
    deque_reply_t       replies_due [$];
    int unsigned        error_count;

    function new();
      front_idx   = '0;
      fill_count  = 0;
      error_count = 0;
    endfunction

    function void note_request(req_e kind, logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
      deque_reply_t     r;
      logic [POS_W-1:0] slot;
      r.data   = '0;
      r.status = ST_OK;
      case (kind)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (fill_count >= RING_DEPTH) begin
            r.status = ST_FULL;
          end else if (kind == REQ_PUSH_FRONT) begin
            front_idx = front_idx - 1'b1;
            ring_mem[front_idx] = value;
            fill_count++;
          end else begin
            slot = front_idx + POS_W'(fill_count);
            ring_mem[slot] = value;
            fill_count++;
          end
        end
        REQ_POP_FRONT, REQ_PEEK_FRONT: begin
          if (fill_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data = ring_mem[front_idx];
            if (kind == REQ_POP_FRONT) begin
              front_idx = front_idx + 1'b1;
              fill_count--;
            end
          end
        end
        REQ_POP_BACK, REQ_PEEK_BACK: begin
          if (fill_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            slot   = front_idx + POS_W'(fill_count - 1);
            r.data = ring_mem[slot];
            if (kind == REQ_POP_BACK) fill_count--;
          end
        end
        REQ_READ_POS: begin
          if (int'(pos) >= fill_count) begin
            r.status = ST_RANGE;
          end else begin
            slot   = front_idx + pos;
            r.data = ring_mem[slot];
          end
        end
        REQ_WRITE_POS: begin
          if (int'(pos) >= fill_count) begin
            r.status = ST_RANGE;
          end else begin
            slot = front_idx + pos;
            ring_mem[slot] = value;
          end
        end
      endcase
      r.held = HELD_W'(fill_count);
      replies_due.push_back(r);
    endfunction

    task report(string what);
      error_count++;
      if (error_count <= MAX_PRINTS) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_reply(logic [VALUE_W-1:0] data, logic [HELD_W-1:0] held, status_e status);
      deque_reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("response with none due: data=%h held=%0d status=%0d",
                         data, held, status));
        return;
      end
      want = replies_due.pop_front();
      if (data !== want.data)
        report($sformatf("data_out got %h want %h", data, want.data));
      if (held !== want.held)
        report($sformatf("items_held got %0d want %0d", held, want.held));
      if (status !== want.status)
        report($sformatf("status got %0d want %0d", status, want.status));
    endtask

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // [31:0] item_value, [41:32] position
  logic [2:0]  s_axis_tuser  = '0;   // [2:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [31:0] data_out, [42:32] items_held
  logic [1:0]  m_axis_tuser;         // [1:0] status

  deque_mirror mirror;
  int unsigned burst_left;
  int unsigned sink_cycle;

  always #10 clk_i = ~clk_i;

  indexed_deque_ring_unit #(
    .RING_DEPTH (RING_DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Receiver back-pressure: the pattern rotates in turn through always ready,
  // coin flips, a sparse duty cycle and long stall windows.
  always @(negedge clk_i) begin
    sink_cycle++;
    case ((sink_cycle >> 7) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(1));
      2: m_axis_tready <= ((sink_cycle % 8) < 2);
      default: m_axis_tready <= (((sink_cycle >> 4) & 3) != 0) && ($urandom_range(3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      mirror.check_reply(m_axis_tdata[31:0], m_axis_tdata[42:32], status_e'(m_axis_tuser));
  end

  // Offer one request word; valid stays up within a burst, gaps fall between bursts.
  task automatic send_req(input req_e kind, input logic [VALUE_W-1:0] value,
                          input logic [POS_W-1:0] pos);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, pos, value};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    mirror.note_request(kind, value, pos);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      repeat ($urandom_range(2) == 0 ? 0 : $urandom_range(1, 6))
        @(negedge clk_i) s_axis_tvalid <= 1'b0;
    end
  endtask

  // Mostly valid positions, some at the boundary, some anywhere in the field.
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned roll;
    roll = $urandom_range(9);
    if (mirror.fill_count == 0 || roll < 2) return POS_W'($urandom);
    if (roll < 4) return POS_W'(mirror.fill_count - $urandom_range(1));
    return POS_W'($urandom_range(mirror.fill_count - 1));
  endfunction

  task automatic send_random(input int unsigned push_pct, input int unsigned pop_pct);
    req_e        kind;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < push_pct)
      kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    else if (roll < push_pct + pop_pct)
      kind = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
    else
      kind = req_e'(3'($urandom_range(REQ_PEEK_FRONT, REQ_WRITE_POS)));
    send_req(kind, VALUE_W'($urandom), pick_position());
  endtask

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL indexed_deque_ring_unit");
    $finish;
  end

  initial begin
    mirror     = new();
    burst_left = $urandom_range(1, 24);
    sink_cycle = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: every request on an empty deque, the data extremes, both ends
    send_req(REQ_POP_FRONT,  '0, '0);
    send_req(REQ_POP_BACK,   '0, '0);
    send_req(REQ_PEEK_FRONT, '0, '0);
    send_req(REQ_PEEK_BACK,  '0, '0);
    send_req(REQ_READ_POS,   '0, '0);
    send_req(REQ_WRITE_POS,  '1, '1);
    send_req(REQ_READ_POS,   '0, '1);
    send_req(REQ_PUSH_BACK,  '1, '0);
    send_req(REQ_PUSH_FRONT, '0, '1);
    send_req(REQ_PUSH_BACK,  32'hA5A5_A5A5, '0);
    send_req(REQ_PUSH_FRONT, 32'h5A5A_5A5A, '0);
    send_req(REQ_PEEK_FRONT, '0, '0);
    send_req(REQ_PEEK_BACK,  '0, '0);
    send_req(REQ_READ_POS,   '0, 10'd3);
    send_req(REQ_READ_POS,   '0, 10'd4);
    send_req(REQ_WRITE_POS,  32'h1234_5678, 10'd2);
    send_req(REQ_READ_POS,   '0, 10'd2);
    send_req(REQ_WRITE_POS,  '1, '1);
    send_req(REQ_POP_FRONT,  '0, '0);
    send_req(REQ_POP_BACK,   '0, '0);
    send_req(REQ_POP_BACK,   '0, '0);
    send_req(REQ_POP_FRONT,  '0, '0);
    send_req(REQ_POP_FRONT,  '0, '0);

    // Random mix around a short deque
    repeat (100) send_random(40, 25);
    // Fill to capacity with reads and overwrites sprinkled in
    while (mirror.fill_count < RING_DEPTH) send_random(92, 0);
    // Full: pushes bounce, last position is addressable
    send_req(REQ_WRITE_POS, VALUE_W'($urandom), '1);
    send_req(REQ_READ_POS,  '0, '1);
    repeat (40) send_random(40, 0);
    // Drain-heavy mix
    repeat (150) send_random(15, 55);

    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mirror.error_count == 0)
      $display("PASS indexed_deque_ring_unit");
    else
      $display("FAIL indexed_deque_ring_unit");
    $finish;
  end

endmodule

[indexed_deque_ring_unit.f]
src/idr_pkg.sv
src/idr_ram.sv
src/idr_ctrl.sv
src/indexed_deque_ring_unit.sv
src/idr_checker.sv
tb/indexed_deque_ring_unit_tb.sv
